// File: rtl/tccw_pkg.sv
`default_nettype none

package tccw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_SPACES = 4;

    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int NCELL_W = $clog2(TAB_SPACES + 1);

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        KIND_CELL   = 2'd0,
        KIND_CLEAR  = 2'd1,
        KIND_CURSOR = 2'd2
    } t_kind;

    typedef struct packed {
        logic              action;
        logic [CHAR_W-1:0] char_code;
    } t_in_item;

    typedef struct packed {
        t_kind             result_kind;
        logic [ROW_W-1:0]  cell_row;
        logic [COL_W-1:0]  cell_column;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attribute;
        logic [ROW_W-1:0]  cursor_row_out;
        logic [COL_W-1:0]  cursor_column_out;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [NCELL_W-1:0] ncells;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [CHAR_W-1:0]  chr;
        logic [ATTR_W-1:0]  attr;
        logic [ROW_W-1:0]   cur_row;
        logic [COL_W-1:0]   cur_col;
        logic               clear;
        logic [COL_W-1:0]   home_col;
    } t_job;

endpackage

`default_nettype wire

// File: rtl/text_console_cursor_writer_core.sv
// an accepted item is held in the job register and each of its results in the output register
// throughput: one result per cycle while the output is not stalled; an item gives 1 to
//   TAB_SPACES+1 results and holds the job register until its last one (a tab with a screen clear is longest)
// a new item is taken in the cycle its predecessor's last result leaves the job register
// reset: no item or result held, cursor at row 1 column 0, attribute 7
`default_nettype none

module text_console_cursor_writer_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire tccw_pkg::t_in_item        i_in_item,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output tccw_pkg::t_out_item            o_out_item,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [tccw_pkg::ATTR_W-1:0] i_cfg_data
);

    logic [tccw_pkg::ATTR_W-1:0]  r_attr;
    logic [tccw_pkg::ROW_W-1:0]   r_cur_row;
    logic [tccw_pkg::COL_W-1:0]   r_cur_col;
    logic [tccw_pkg::ROW_W-1:0]   n_cur_row;
    logic [tccw_pkg::COL_W-1:0]   n_cur_col;
    logic                         r_jv;
    tccw_pkg::t_job               r_job;
    tccw_pkg::t_job               n_job;
    logic [tccw_pkg::NCELL_W-1:0] r_idx;
    logic                         r_ov;
    tccw_pkg::t_out_item          r_out;
    tccw_pkg::t_out_item          n_out;

    logic                         accept;
    logic                         emit;
    logic [tccw_pkg::ROW_W-1:0]   inc_row;
    logic [tccw_pkg::COL_W:0]     tab_sum;
    logic [tccw_pkg::COL_W:0]     tab_room;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    assign emit       = r_jv && (!r_ov || i_out_ready);
    assign o_in_ready = !r_jv || (emit && n_out.last);
    assign accept     = i_in_valid && o_in_ready;

    assign inc_row  = r_cur_row + 1'b1;
    assign tab_sum  = {1'b0, r_cur_col} + (tccw_pkg::COL_W+1)'(tccw_pkg::TAB_SPACES);
    assign tab_room = (tccw_pkg::COL_W+1)'(tccw_pkg::COLUMNS) - {1'b0, r_cur_col};

    // build the job for the incoming item
    always_comb begin
        n_job          = '0;
        n_job.row      = r_cur_row;
        n_job.col      = r_cur_col;
        n_job.chr      = i_in_item.char_code;
        n_job.attr     = r_attr;
        n_job.cur_row  = r_cur_row;
        n_job.cur_col  = r_cur_col;
        n_job.home_col = tccw_pkg::COL_W'(1);
        if (i_in_item.action == tccw_pkg::ACT_CLEAR) begin
            n_job.clear    = 1'b1;
            n_job.home_col = '0;
        end else begin
            if (i_in_item.char_code == tccw_pkg::CH_NEWLINE) begin
                n_job.cur_row = inc_row;
                n_job.cur_col = '0;
            end else if (i_in_item.char_code == tccw_pkg::CH_TAB) begin
                n_job.chr = tccw_pkg::CH_SPACE;
                if (tab_room >= (tccw_pkg::COL_W+1)'(tccw_pkg::TAB_SPACES)) begin
                    n_job.ncells = tccw_pkg::NCELL_W'(tccw_pkg::TAB_SPACES);
                end else begin
                    n_job.ncells = tccw_pkg::NCELL_W'(tab_room);
                end
                if (tab_sum >= (tccw_pkg::COL_W+1)'(tccw_pkg::COLUMNS)) begin
                    n_job.cur_row = inc_row;
                    n_job.cur_col = '0;
                end else begin
                    n_job.cur_col = tab_sum[tccw_pkg::COL_W-1:0];
                end
            end else if (i_in_item.char_code == tccw_pkg::CH_BACKSPACE) begin
                n_job.chr = tccw_pkg::CH_SPACE;
                if (r_cur_col != '0) begin
                    n_job.ncells  = tccw_pkg::NCELL_W'(1);
                    n_job.col     = r_cur_col - 1'b1;
                    n_job.cur_col = r_cur_col - 1'b1;
                end
            end else begin
                n_job.ncells = tccw_pkg::NCELL_W'(1);
                if ({1'b0, r_cur_col} + 1'b1 >= (tccw_pkg::COL_W+1)'(tccw_pkg::COLUMNS)) begin
                    n_job.cur_row = inc_row;
                    n_job.cur_col = '0;
                end else begin
                    n_job.cur_col = r_cur_col + 1'b1;
                end
            end
            n_job.clear = (n_job.cur_row >= tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1));
        end
    end

    always_comb begin
        if (n_job.clear) begin
            n_cur_row = tccw_pkg::ROW_W'(1);
            n_cur_col = n_job.home_col;
        end else begin
            n_cur_row = n_job.cur_row;
            n_cur_col = n_job.cur_col;
        end
    end

    // result selected by the step counter
    always_comb begin
        n_out = '0;
        if (r_idx < r_job.ncells) begin
            n_out.result_kind       = tccw_pkg::KIND_CELL;
            n_out.cell_row          = r_job.row;
            n_out.cell_column       = r_job.col + tccw_pkg::COL_W'(r_idx);
            n_out.cell_char         = r_job.chr;
            n_out.cell_attribute    = r_job.attr;
            n_out.cursor_row_out    = r_job.cur_row;
            n_out.cursor_column_out = r_job.cur_col;
            n_out.last = (tccw_pkg::NCELL_W'(r_idx + 1'b1) == r_job.ncells) && !r_job.clear;
        end else if (r_job.clear) begin
            n_out.result_kind       = tccw_pkg::KIND_CLEAR;
            n_out.cell_char         = tccw_pkg::CH_SPACE;
            n_out.cell_attribute    = r_job.attr;
            n_out.cursor_row_out    = tccw_pkg::ROW_W'(1);
            n_out.cursor_column_out = r_job.home_col;
            n_out.last              = 1'b1;
        end else begin
            n_out.result_kind       = tccw_pkg::KIND_CURSOR;
            n_out.cursor_row_out    = r_job.cur_row;
            n_out.cursor_column_out = r_job.cur_col;
            n_out.last              = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr    <= tccw_pkg::ATTR_RESET;
            r_cur_row <= tccw_pkg::ROW_W'(1);
            r_cur_col <= '0;
            r_jv      <= 1'b0;
            r_idx     <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_attr <= i_cfg_data;
            end
            if (accept) begin
                r_cur_row <= n_cur_row;
                r_cur_col <= n_cur_col;
                r_jv      <= 1'b1;
            end else if (emit && n_out.last) begin
                r_jv <= 1'b0;
            end
            if (emit) begin
                r_idx <= n_out.last ? '0 : r_idx + 1'b1;
                r_ov  <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire
